// File: hw/rtl/i2cbb_pkg.sv
// Package for the I2C bit-level master: phase codes, command codes, the
// transaction payload structs and the internal state record.
// No dependencies; used by i2cbb_step, i2c_bitbang_master and i2cbb_checker.
package i2cbb_pkg;

    localparam int DELAY_COUNT_WIDTH = 16;
    localparam int CFG_WIDTH         = 16;

    typedef logic [DELAY_COUNT_WIDTH-1:0] delay_t;
    typedef logic [CFG_WIDTH-1:0]         cfg_t;

    localparam delay_t DELAY_MAX = '1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ST1   = 4'd1,
        PH_ST2   = 4'd2,
        PH_ST3   = 4'd3,
        PH_ST4   = 4'd4,
        PH_SP1   = 4'd5,
        PH_SP2   = 4'd6,
        PH_SP3   = 4'd7,
        PH_BLOW  = 4'd8,
        PH_BHIGH = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Number of data bits in a byte slot sequence before the acknowledge slot.
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_sample;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_bit;
    } res_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        delay_t     delay_count;
        logic       pending_ack;
        logic       last_ack;
        logic [7:0] last_read;
        logic       scl;
        logic       sda;
        logic [2:0] command_kind;
    } state_t;

endpackage

// File: hw/rtl/i2c_bitbang_master.sv
// Top level of the I2C bit-level master: handshakes, state and result registers.
// Depends on i2cbb_pkg and i2cbb_step.
//
//   Channel   Ports                        Payload                Direction
//   -------   --------------------------   --------------------   ---------
//   input     s_valid, s_ready, s_data     i2cbb_pkg::in_t        in
//   result    m_valid, m_ready, m_data     i2cbb_pkg::res_t       out
//   config    cfg_valid, cfg_ready, cfg_data  ticks_per_phase     in
//
// Every input transaction is one tick of the bit timer and produces exactly one
// result transaction. The step logic sits between the state registers and the
// result register, so a tick is accepted every cycle while the result side
// keeps up; s_ready drops only while a result is held and m_ready is low.
// Reset (aresetn low, synchronous) releases both lines, returns to idle and
// sets ticks_per_phase to one.
module i2c_bitbang_master (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2cbb_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output i2cbb_pkg::res_t   m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  i2cbb_pkg::cfg_t   cfg_data
);

    i2cbb_pkg::state_t state_reg;
    i2cbb_pkg::state_t state_next;
    i2cbb_pkg::res_t   res_reg;
    i2cbb_pkg::res_t   res_next;
    logic              m_valid_reg;
    i2cbb_pkg::cfg_t   ticks_reg;
    i2cbb_pkg::delay_t period;
    logic              s_accept;

    // The register may always be written; the block is idle by agreement.
    assign cfg_ready = 1'b1;

    // A result register that is empty or being drained makes room for the next tick.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = res_reg;

    // Phase length: zero behaves as one, and a value too wide for the delay
    // counter saturates at its largest count.
    always_comb begin
        if (ticks_reg == '0) begin
            period = i2cbb_pkg::delay_t'(1);
        end else if (32'(ticks_reg) > 32'(i2cbb_pkg::DELAY_MAX)) begin
            period = i2cbb_pkg::DELAY_MAX;
        end else begin
            period = i2cbb_pkg::delay_t'(ticks_reg);
        end
    end

    i2cbb_step u_step (
        .st      (state_reg),
        .in_item (s_data),
        .period  (period),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= i2cbb_pkg::PH_IDLE;
            state_reg.bit_count    <= '0;
            state_reg.shift_byte   <= '0;
            state_reg.delay_count  <= '0;
            state_reg.pending_ack  <= 1'b0;
            state_reg.last_ack     <= 1'b0;
            state_reg.last_read    <= '0;
            state_reg.scl          <= 1'b1;
            state_reg.sda          <= 1'b1;
            state_reg.command_kind <= '0;
            m_valid_reg            <= 1'b0;
            ticks_reg              <= i2cbb_pkg::cfg_t'(1);
        end else begin
            if (cfg_valid && cfg_ready) begin
                ticks_reg <= cfg_data;
            end
            if (s_accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

endmodule

// File: hw/rtl/i2cbb_step.sv
// Next-state and result logic of the I2C bit-level master for one tick.
// Depends on i2cbb_pkg. Purely combinational; the registers live in the top level.
module i2cbb_step (
    input  i2cbb_pkg::state_t st,
    input  i2cbb_pkg::in_t    in_item,
    input  i2cbb_pkg::delay_t period,
    output i2cbb_pkg::state_t st_next,
    output i2cbb_pkg::res_t   res
);

    logic done;

    // SDA level driven in the SCL-low phase of a slot.
    function automatic logic slot_bit(input logic [3:0] bc, input logic [7:0] sb,
                                      input logic [2:0] kind, input logic pack);
        logic is_write;
        is_write = (kind == i2cbb_pkg::OP_WRITE);
        if (bc < i2cbb_pkg::BITS_PER_BYTE) begin
            slot_bit = is_write ? sb[7] : 1'b1;
        end else begin
            slot_bit = is_write ? 1'b1 : !pack;
        end
    endfunction

    always_comb begin
        st_next = st;
        done    = 1'b0;
        case (st.phase)
            i2cbb_pkg::PH_IDLE: begin
                case (in_item.operation)
                    i2cbb_pkg::OP_START: begin
                        st_next.command_kind = in_item.operation;
                        st_next.phase        = i2cbb_pkg::PH_ST1;
                        st_next.delay_count  = i2cbb_pkg::delay_t'(1);
                        st_next.sda          = 1'b1;
                    end
                    i2cbb_pkg::OP_STOP: begin
                        st_next.command_kind = in_item.operation;
                        st_next.phase        = i2cbb_pkg::PH_SP1;
                        st_next.delay_count  = i2cbb_pkg::delay_t'(1);
                        st_next.sda          = 1'b0;
                    end
                    i2cbb_pkg::OP_WRITE, i2cbb_pkg::OP_READ: begin
                        st_next.command_kind = in_item.operation;
                        st_next.bit_count    = 4'd0;
                        if (in_item.operation == i2cbb_pkg::OP_WRITE) begin
                            st_next.shift_byte = in_item.write_byte;
                        end else begin
                            st_next.shift_byte  = 8'd0;
                            st_next.pending_ack = in_item.send_ack;
                        end
                        st_next.phase       = i2cbb_pkg::PH_BLOW;
                        st_next.delay_count = i2cbb_pkg::delay_t'(1);
                        st_next.scl         = 1'b0;
                        st_next.sda         = slot_bit(4'd0, st_next.shift_byte,
                                                       in_item.operation,
                                                       st_next.pending_ack);
                    end
                    default: begin
                    end
                endcase
            end
            i2cbb_pkg::PH_ST1, i2cbb_pkg::PH_ST2, i2cbb_pkg::PH_ST3, i2cbb_pkg::PH_ST4,
            i2cbb_pkg::PH_SP1, i2cbb_pkg::PH_SP2, i2cbb_pkg::PH_SP3,
            i2cbb_pkg::PH_BLOW, i2cbb_pkg::PH_BHIGH: begin
                if (st.delay_count < period) begin
                    st_next.delay_count = st.delay_count + i2cbb_pkg::delay_t'(1);
                end else begin
                    st_next.delay_count = i2cbb_pkg::delay_t'(1);
                    case (st.phase)
                        i2cbb_pkg::PH_ST1: begin
                            st_next.phase = i2cbb_pkg::PH_ST2;
                            st_next.scl   = 1'b1;
                        end
                        i2cbb_pkg::PH_ST2: begin
                            st_next.phase = i2cbb_pkg::PH_ST3;
                            st_next.sda   = 1'b0;
                        end
                        i2cbb_pkg::PH_ST3: begin
                            st_next.phase = i2cbb_pkg::PH_ST4;
                            st_next.scl   = 1'b0;
                        end
                        i2cbb_pkg::PH_SP1: begin
                            st_next.phase = i2cbb_pkg::PH_SP2;
                            st_next.scl   = 1'b1;
                        end
                        i2cbb_pkg::PH_SP2: begin
                            st_next.phase = i2cbb_pkg::PH_SP3;
                            st_next.sda   = 1'b1;
                        end
                        i2cbb_pkg::PH_BLOW: begin
                            st_next.phase = i2cbb_pkg::PH_BHIGH;
                            st_next.scl   = 1'b1;
                        end
                        i2cbb_pkg::PH_ST4, i2cbb_pkg::PH_SP3: begin
                            // Finishing does not restart the phase timer.
                            st_next.delay_count = st.delay_count;
                            st_next.phase       = i2cbb_pkg::PH_IDLE;
                            done                = 1'b1;
                        end
                        default: begin
                            // End of an SCL-high phase: next slot or finish.
                            if (st.bit_count < i2cbb_pkg::BITS_PER_BYTE) begin
                                if (st.command_kind == i2cbb_pkg::OP_WRITE) begin
                                    st_next.shift_byte = {st.shift_byte[6:0], 1'b0};
                                end else begin
                                    st_next.shift_byte = {st.shift_byte[6:0],
                                                          in_item.sda_sample};
                                end
                                st_next.bit_count = st.bit_count + 4'd1;
                                st_next.phase     = i2cbb_pkg::PH_BLOW;
                                st_next.scl       = 1'b0;
                                st_next.sda       = slot_bit(st_next.bit_count,
                                                             st_next.shift_byte,
                                                             st.command_kind,
                                                             st.pending_ack);
                            end else begin
                                if (st.command_kind == i2cbb_pkg::OP_WRITE) begin
                                    st_next.last_ack = in_item.sda_sample;
                                end else begin
                                    st_next.last_read = st.shift_byte;
                                end
                                st_next.delay_count = st.delay_count;
                                st_next.scl         = 1'b0;
                                st_next.sda         = 1'b1;
                                st_next.phase       = i2cbb_pkg::PH_IDLE;
                                done                = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                // A phase code outside the sequence drops back to idle silently.
                st_next.phase = i2cbb_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        res.scl_level = st_next.scl;
        res.sda_level = st_next.sda;
        res.busy_res  = (st_next.phase != i2cbb_pkg::PH_IDLE);
        res.done_res  = done;
        res.read_byte = st_next.last_read;
        res.ack_bit   = st_next.last_ack;
    end

endmodule

// File: hw/rtl/i2cbb_checker.sv
// Port-level checker for the I2C bit-level master, bound to the top level.
// Depends on i2cbb_pkg and i2c_bitbang_master.
module i2cbb_props (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input i2cbb_pkg::res_t m_data
);

    // A finished command is never reported as still in progress.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done_res with busy_res set");

    // Every command ends with SDA released or with SCL held low.
    a_done_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.sda_level || !m_data.scl_level)
        else $error("command finished with SCL high and SDA low");

    // A draining result side never throttles the input side.
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind i2c_bitbang_master i2cbb_props u_i2cbb_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
